// ----- rtl/core/cid_pkg.sv -----
// ----------------------------------------------------------------------------
// cid_pkg
// Shared widths, codes and types of the crash impact detector.
// ----------------------------------------------------------------------------
`default_nettype none

package cid_pkg;

    localparam int SAMPLE_BITS  = 16;
    localparam int THR_W        = 16;
    localparam int OFFSET_W     = 15;
    localparam int TIME_W       = 32;
    localparam int MAG_W        = 16;
    localparam int MSG_W        = 2;
    localparam int CFG_INDEX_W  = 3;
    localparam int CFG_DATA_W   = 16;

    // magnitude of one axis after offset removal, and its signed form
    localparam int AXIS_W  = ((SAMPLE_BITS > OFFSET_W) ? SAMPLE_BITS : OFFSET_W) + 1;
    localparam int DIFF_W  = AXIS_W + 1;
    localparam int SUM_W   = 2 * AXIS_W + 2;
    localparam int ROOT_W  = SUM_W / 2;
    localparam int REM_W   = ROOT_W + 2;
    localparam int CMP_W   = (ROOT_W > MAG_W + 1) ? ROOT_W : MAG_W + 1;
    localparam int ROOT_CNT_W = $clog2(ROOT_W);

    localparam logic [THR_W-1:0]    CRASH_THR_RST     = 16'd15565;
    localparam logic [THR_W-1:0]    WARNING_THR_RST   = 16'd8192;
    localparam logic [OFFSET_W-1:0] GRAVITY_RST       = 15'd4096;
    localparam logic [THR_W-1:0]    PERSIST_RST       = 16'd25;
    localparam logic [THR_W-1:0]    CRASH_HOLDOFF_RST = 16'd5000;
    localparam logic [THR_W-1:0]    WARN_HOLDOFF_RST  = 16'd1000;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_CRASH_THR     = 3'd0,
        CFG_WARNING_THR   = 3'd1,
        CFG_GRAVITY       = 3'd2,
        CFG_PERSIST       = 3'd3,
        CFG_CRASH_HOLDOFF = 3'd4,
        CFG_WARN_HOLDOFF  = 3'd5
    } cfg_index_t;

    typedef enum logic [MSG_W-1:0] {
        MSG_NONE    = 2'd0,
        MSG_WARNING = 2'd1,
        MSG_CRASH   = 2'd2
    } msg_t;

    typedef enum logic [1:0] {
        AXIS_X = 2'd0,
        AXIS_Y = 2'd1,
        AXIS_Z = 2'd2
    } axis_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LOAD,
        ST_SQ_X,
        ST_SQ_Y,
        ST_SQ_Z,
        ST_ACC,
        ST_ROOT,
        ST_DECIDE
    } state_t;

    typedef struct packed {
        logic [THR_W-1:0]    crash_threshold;
        logic [THR_W-1:0]    warning_threshold;
        logic [OFFSET_W-1:0] gravity_offset;
        logic [THR_W-1:0]    persist_ms;
        logic [THR_W-1:0]    crash_holdoff_ms;
        logic [THR_W-1:0]    warning_holdoff_ms;
    } cfg_t;

    typedef struct packed {
        logic  capture;
        logic  prep;
        logic  mul_en;
        axis_t mul_sel;
        logic  acc_load;
        logic  acc_add;
        logic  root_init;
        logic  root_step;
        logic  decide;
    } ctrl_cmd_t;

    typedef struct packed {
        logic out_free;
    } dp_status_t;

endpackage

`default_nettype wire

// ----- rtl/core/cid_intf.sv -----
// ----------------------------------------------------------------------------
// cid_intf
// Sample, result and configuration channels of the crash impact detector.
// ----------------------------------------------------------------------------
`default_nettype none

interface cid_sample_if;
    logic                                    valid;
    logic                                    ready;
    logic signed [cid_pkg::SAMPLE_BITS-1:0] accel_x;
    logic signed [cid_pkg::SAMPLE_BITS-1:0] accel_y;
    logic signed [cid_pkg::SAMPLE_BITS-1:0] accel_z;
    logic [cid_pkg::TIME_W-1:0]              now_ms;

    modport source (output valid, accel_x, accel_y, accel_z, now_ms, input ready);
    modport sink   (input valid, accel_x, accel_y, accel_z, now_ms, output ready);
endinterface

interface cid_result_if;
    logic                       valid;
    logic                       ready;
    logic [cid_pkg::MSG_W-1:0]  message;
    logic [cid_pkg::MAG_W-1:0]  magnitude;
    logic                       ignored;

    modport source (output valid, message, magnitude, ignored, input ready);
    modport sink   (input valid, message, magnitude, ignored, output ready);
endinterface

interface cid_cfg_if;
    logic                             valid;
    logic                             ready;
    logic [cid_pkg::CFG_INDEX_W-1:0]  index;
    logic [cid_pkg::CFG_DATA_W-1:0]   data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

// ----- rtl/core/cid_cfg_regs.sv -----
// ----------------------------------------------------------------------------
// cid_cfg_regs
// Threshold, offset and timing registers written over the configuration port.
// ----------------------------------------------------------------------------
`default_nettype none

module cid_cfg_regs (
    input  wire logic    clk,
    input  wire logic    rst_n,
    cid_cfg_if.sink      cfg,
    output cid_pkg::cfg_t cfg_q
);

    cid_pkg::cfg_t cfg_reg;
    cid_pkg::cfg_t cfg_next;

    assign cfg.ready = 1'b1;
    assign cfg_q     = cfg_reg;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg.valid)
        begin
            case (cfg.index)
                cid_pkg::CFG_CRASH_THR:     cfg_next.crash_threshold    = cfg.data;
                cid_pkg::CFG_WARNING_THR:   cfg_next.warning_threshold  = cfg.data;
                cid_pkg::CFG_GRAVITY:
                    cfg_next.gravity_offset = cfg.data[cid_pkg::OFFSET_W-1:0];
                cid_pkg::CFG_PERSIST:       cfg_next.persist_ms         = cfg.data;
                cid_pkg::CFG_CRASH_HOLDOFF: cfg_next.crash_holdoff_ms   = cfg.data;
                cid_pkg::CFG_WARN_HOLDOFF:  cfg_next.warning_holdoff_ms = cfg.data;
                default:                    cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.crash_threshold    <= cid_pkg::CRASH_THR_RST;
            cfg_reg.warning_threshold  <= cid_pkg::WARNING_THR_RST;
            cfg_reg.gravity_offset     <= cid_pkg::GRAVITY_RST;
            cfg_reg.persist_ms         <= cid_pkg::PERSIST_RST;
            cfg_reg.crash_holdoff_ms   <= cid_pkg::CRASH_HOLDOFF_RST;
            cfg_reg.warning_holdoff_ms <= cid_pkg::WARN_HOLDOFF_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

`default_nettype wire

// ----- rtl/core/cid_ctrl.sv -----
// ----------------------------------------------------------------------------
// cid_ctrl
// Sequencer: capture, three squarings, accumulation, root steps, decision.
// ----------------------------------------------------------------------------
`default_nettype none

module cid_ctrl (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    output logic                    in_ready,
    input  wire cid_pkg::dp_status_t status,
    output cid_pkg::ctrl_cmd_t      cmd
);

    cid_pkg::state_t state_reg;
    cid_pkg::state_t state_next;

    logic [cid_pkg::ROOT_CNT_W-1:0] cnt_reg;
    logic [cid_pkg::ROOT_CNT_W-1:0] cnt_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= cid_pkg::ST_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        in_ready   = 1'b0;
        cmd        = '0;
        cmd.mul_sel = cid_pkg::AXIS_X;

        case (state_reg)
            cid_pkg::ST_IDLE:
            begin
                in_ready    = 1'b1;
                cmd.capture = in_valid;
                if (in_valid)
                begin
                    state_next = cid_pkg::ST_LOAD;
                end
            end
            cid_pkg::ST_LOAD:
            begin
                cmd.prep   = 1'b1;
                state_next = cid_pkg::ST_SQ_X;
            end
            cid_pkg::ST_SQ_X:
            begin
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = cid_pkg::AXIS_X;
                state_next  = cid_pkg::ST_SQ_Y;
            end
            cid_pkg::ST_SQ_Y:
            begin
                cmd.mul_en   = 1'b1;
                cmd.mul_sel  = cid_pkg::AXIS_Y;
                cmd.acc_load = 1'b1;
                state_next   = cid_pkg::ST_SQ_Z;
            end
            cid_pkg::ST_SQ_Z:
            begin
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = cid_pkg::AXIS_Z;
                cmd.acc_add = 1'b1;
                state_next  = cid_pkg::ST_ACC;
            end
            cid_pkg::ST_ACC:
            begin
                cmd.acc_add   = 1'b1;
                cmd.root_init = 1'b1;
                cnt_next      = cid_pkg::ROOT_CNT_W'(cid_pkg::ROOT_W - 1);
                state_next    = cid_pkg::ST_ROOT;
            end
            cid_pkg::ST_ROOT:
            begin
                cmd.root_step = 1'b1;
                cnt_next      = cnt_reg - 1'b1;
                if (cnt_reg == '0)
                begin
                    state_next = cid_pkg::ST_DECIDE;
                end
            end
            cid_pkg::ST_DECIDE:
            begin
                // wait for the result register to drain
                if (status.out_free)
                begin
                    cmd.decide = 1'b1;
                    state_next = cid_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = cid_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

// ----- rtl/core/cid_datapath.sv -----
// ----------------------------------------------------------------------------
// cid_datapath
// Sample registers, shared squarer, root unit, detection state and result.
// ----------------------------------------------------------------------------
`default_nettype none

module cid_datapath (
    input  wire logic                                   clk,
    input  wire logic                                   rst_n,
    input  wire cid_pkg::cfg_t                          cfg_q,
    input  wire cid_pkg::ctrl_cmd_t                     cmd,
    output cid_pkg::dp_status_t                         status,
    input  wire logic signed [cid_pkg::SAMPLE_BITS-1:0] accel_x,
    input  wire logic signed [cid_pkg::SAMPLE_BITS-1:0] accel_y,
    input  wire logic signed [cid_pkg::SAMPLE_BITS-1:0] accel_z,
    input  wire logic [cid_pkg::TIME_W-1:0]             now_ms,
    output logic                                        out_valid,
    input  wire logic                                   out_ready,
    output logic [cid_pkg::MSG_W-1:0]                   message,
    output logic [cid_pkg::MAG_W-1:0]                   magnitude,
    output logic                                        ignored
);

    localparam int SB   = cid_pkg::SAMPLE_BITS;
    localparam int AW   = cid_pkg::AXIS_W;
    localparam int DW   = cid_pkg::DIFF_W;
    localparam int SW   = cid_pkg::SUM_W;
    localparam int RW   = cid_pkg::ROOT_W;
    localparam int MW   = cid_pkg::REM_W;
    localparam int CW   = cid_pkg::CMP_W;
    localparam int TW   = cid_pkg::TIME_W;

    function automatic logic [AW-1:0] abs_val(input logic signed [DW-1:0] v);
        logic signed [DW-1:0] n;
        n = v[DW-1] ? -v : v;
        return n[AW-1:0];
    endfunction

    // sample
    logic signed [SB-1:0] x_reg;
    logic signed [SB-1:0] y_reg;
    logic signed [SB-1:0] z_reg;
    logic [TW-1:0]        now_reg;

    // prepared operands
    logic [AW-1:0] ax_reg;
    logic [AW-1:0] ay_reg;
    logic [AW-1:0] az_reg;
    logic [TW-1:0] hold_diff_reg;
    logic [TW-1:0] persist_diff_reg;

    // squarer and accumulator
    logic [AW-1:0]   mul_op;
    logic [2*AW-1:0] prod_next;
    logic [2*AW-1:0] prod_reg;
    logic [SW-1:0]   sum_reg;

    // root unit
    logic [RW-1:0] root_reg;
    logic [MW-1:0] rem_reg;
    logic [MW-1:0] rem_shift;
    logic [MW-1:0] trial;

    // detection state
    logic          armed_reg;
    logic          armed_next;
    logic [TW-1:0] impact_start_reg;
    logic [TW-1:0] impact_start_next;
    logic          holdoff_active_reg;
    logic          holdoff_active_next;
    logic [TW-1:0] holdoff_start_reg;
    logic [TW-1:0] holdoff_start_next;
    logic [cid_pkg::THR_W-1:0] holdoff_length_reg;
    logic [cid_pkg::THR_W-1:0] holdoff_length_next;

    // result
    logic                     out_valid_reg;
    logic                     out_valid_next;
    cid_pkg::msg_t            message_reg;
    cid_pkg::msg_t            msg_next;
    logic [cid_pkg::MAG_W-1:0] magnitude_reg;
    logic [cid_pkg::MAG_W-1:0] mag_sat;
    logic                     ignored_reg;
    logic                     ign_next;

    logic [CW-1:0] mag_ext;
    logic [CW-1:0] crash_ext;
    logic [CW-1:0] warn_ext;
    logic          above_crash;

    // sample capture on transaction
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            x_reg   <= accel_x;
            y_reg   <= accel_y;
            z_reg   <= accel_z;
            now_reg <= now_ms;
        end
    end

    // absolute axis values and time differences
    always_ff @(posedge clk)
    begin
        if (cmd.prep)
        begin
            ax_reg <= abs_val(DW'(x_reg));
            ay_reg <= abs_val(DW'(y_reg));
            az_reg <= abs_val(DW'(z_reg) - DW'($signed({1'b0, cfg_q.gravity_offset})));
            hold_diff_reg    <= now_reg - holdoff_start_reg;
            persist_diff_reg <= now_reg - impact_start_reg;
        end
    end

    always_comb
    begin
        case (cmd.mul_sel)
            cid_pkg::AXIS_X: mul_op = ax_reg;
            cid_pkg::AXIS_Y: mul_op = ay_reg;
            cid_pkg::AXIS_Z: mul_op = az_reg;
            default:         mul_op = ax_reg;
        endcase
    end

    assign prod_next = mul_op * mul_op;

    assign rem_shift = {rem_reg[RW-1:0], sum_reg[SW-1 -: 2]};
    assign trial     = {root_reg, 2'b01};

    always_ff @(posedge clk)
    begin
        if (cmd.mul_en)
        begin
            prod_reg <= prod_next;
        end

        if (cmd.acc_load)
        begin
            sum_reg <= SW'(prod_reg);
        end
        else if (cmd.acc_add)
        begin
            sum_reg <= sum_reg + SW'(prod_reg);
        end
        else if (cmd.root_step)
        begin
            sum_reg <= {sum_reg[SW-3:0], 2'b00};
        end

        if (cmd.root_init)
        begin
            root_reg <= '0;
            rem_reg  <= '0;
        end
        else if (cmd.root_step)
        begin
            if (rem_shift >= trial)
            begin
                rem_reg  <= rem_shift - trial;
                root_reg <= {root_reg[RW-2:0], 1'b1};
            end
            else
            begin
                rem_reg  <= rem_shift;
                root_reg <= {root_reg[RW-2:0], 1'b0};
            end
        end
    end

    // decision
    assign mag_ext     = CW'(root_reg);
    assign crash_ext   = CW'(cfg_q.crash_threshold);
    assign warn_ext    = CW'(cfg_q.warning_threshold);
    assign above_crash = mag_ext > crash_ext;

    always_comb
    begin
        if (mag_ext > CW'({cid_pkg::MAG_W{1'b1}}))
        begin
            mag_sat = '1;
        end
        else
        begin
            mag_sat = mag_ext[cid_pkg::MAG_W-1:0];
        end
    end

    always_comb
    begin
        armed_next          = armed_reg;
        impact_start_next   = impact_start_reg;
        holdoff_active_next = holdoff_active_reg;
        holdoff_start_next  = holdoff_start_reg;
        holdoff_length_next = holdoff_length_reg;
        msg_next            = cid_pkg::MSG_NONE;
        ign_next            = 1'b0;

        if (holdoff_active_reg && (hold_diff_reg < TW'(holdoff_length_reg)))
        begin
            ign_next = 1'b1;
        end
        else
        begin
            holdoff_active_next = 1'b0;
            if (above_crash)
            begin
                if (!armed_reg)
                begin
                    armed_next        = 1'b1;
                    impact_start_next = now_reg;
                end
                else if (persist_diff_reg > TW'(cfg_q.persist_ms))
                begin
                    msg_next            = cid_pkg::MSG_CRASH;
                    armed_next          = 1'b0;
                    holdoff_active_next = 1'b1;
                    holdoff_start_next  = now_reg;
                    holdoff_length_next = cfg_q.crash_holdoff_ms;
                end
            end
            else
            begin
                armed_next = 1'b0;
            end

            if ((mag_ext > warn_ext) && (mag_ext < crash_ext))
            begin
                msg_next            = cid_pkg::MSG_WARNING;
                holdoff_active_next = 1'b1;
                holdoff_start_next  = now_reg;
                holdoff_length_next = cfg_q.warning_holdoff_ms;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            armed_reg          <= 1'b0;
            impact_start_reg   <= '0;
            holdoff_active_reg <= 1'b0;
            holdoff_start_reg  <= '0;
            holdoff_length_reg <= '0;
        end
        else if (cmd.decide)
        begin
            armed_reg          <= armed_next;
            impact_start_reg   <= impact_start_next;
            holdoff_active_reg <= holdoff_active_next;
            holdoff_start_reg  <= holdoff_start_next;
            holdoff_length_reg <= holdoff_length_next;
        end
    end

    // result register
    always_comb
    begin
        if (cmd.decide)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.decide)
        begin
            message_reg   <= msg_next;
            magnitude_reg <= mag_sat;
            ignored_reg   <= ign_next;
        end
    end

    assign status.out_free = !out_valid_reg || out_ready;
    assign out_valid       = out_valid_reg;
    assign message         = message_reg;
    assign magnitude       = magnitude_reg;
    assign ignored         = ignored_reg;

endmodule

`default_nettype wire

// ----- rtl/core/crash_impact_detector_top.sv -----
// ----------------------------------------------------------------------------
// crash_impact_detector_top
// Accelerometer impact detector with crash persistence and warning hold-off.
// ----------------------------------------------------------------------------
// Each sample transaction yields exactly one result transaction: the floor
// root of x^2 + y^2 + (z - gravity_offset)^2, saturated to 16 bits, a message
// code (none, warning, crash) and a flag marking samples dropped in hold-off.
// One sample is worked on at a time; the next sample is accepted only after
// the three passes through the shared squarer and the one-bit-per-cycle
// square root. A finished result waits in the output register while the
// next sample is accepted. The configuration port is always ready and must
// be written only while no sample is in flight.
// ----------------------------------------------------------------------------
`default_nettype none

module crash_impact_detector_top (
    input  wire logic     clk,
    input  wire logic     rst_n,
    cid_sample_if.sink    sample,
    cid_result_if.source  result,
    cid_cfg_if.sink       cfg
);

    cid_pkg::cfg_t       cfg_q;
    cid_pkg::ctrl_cmd_t  cmd;
    cid_pkg::dp_status_t status;
    logic                in_ready;

    assign sample.ready = in_ready;

    cid_cfg_regs u_cfg_regs (
        .clk   (clk),
        .rst_n (rst_n),
        .cfg   (cfg),
        .cfg_q (cfg_q)
    );

    cid_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (sample.valid),
        .in_ready (in_ready),
        .status   (status),
        .cmd      (cmd)
    );

    cid_datapath u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_q     (cfg_q),
        .cmd       (cmd),
        .status    (status),
        .accel_x   (sample.accel_x),
        .accel_y   (sample.accel_y),
        .accel_z   (sample.accel_z),
        .now_ms    (sample.now_ms),
        .out_valid (result.valid),
        .out_ready (result.ready),
        .message   (result.message),
        .magnitude (result.magnitude),
        .ignored   (result.ignored)
    );

endmodule

`default_nettype wire
